FILE: hdl/mfde_pkg.sv
// Shared constants, command codes and the 5x7 font for the monochrome drawing engine.
// No dependencies.
`default_nettype none
package mfde_pkg;
	localparam int ScreenWidth = 128;
	localparam int ScreenHeight = 64;
	localparam int StoreBytes = ScreenWidth * ScreenHeight / 8;
	localparam int AddrW = $clog2(StoreBytes);
	localparam int GlyphCols = 5;
	localparam int GlyphRows = 7;

	localparam logic [2:0] REQ_CLEAR = 3'd0;
	localparam logic [2:0] REQ_PIXEL = 3'd1;
	localparam logic [2:0] REQ_HLINE = 3'd2;
	localparam logic [2:0] REQ_VLINE = 3'd3;
	localparam logic [2:0] REQ_RECT  = 3'd4;
	localparam logic [2:0] REQ_GLYPH = 3'd5;
	localparam logic [2:0] REQ_READ  = 3'd6;

	// one font column for a character code and column index
	function automatic logic [6:0] font_col(input logic [7:0] code, input logic [2:0] col);
		logic [7:0] c;
		logic [39:0] g;
		begin
			c = code;
			g = 40'h0;
			if (c >= 8'd97 && c <= 8'd122) c = c - 8'd32;
			case (c)
				8'd65: g = 40'h7E1111117E;
				8'd66: g = 40'h7F49494936;
				8'd67: g = 40'h3E41414122;
				8'd68: g = 40'h7F4141221C;
				8'd69: g = 40'h7F49494941;
				8'd70: g = 40'h7F09090901;
				8'd71: g = 40'h3E4149497A;
				8'd72: g = 40'h7F0808087F;
				8'd73: g = 40'h00417F4100;
				8'd74: g = 40'h2040413F01;
				8'd75: g = 40'h7F08142241;
				8'd76: g = 40'h7F40404040;
				8'd77: g = 40'h7F020C027F;
				8'd78: g = 40'h7F0408107F;
				8'd79: g = 40'h3E4141413E;
				8'd80: g = 40'h7F09090906;
				8'd81: g = 40'h3E4151215E;
				8'd82: g = 40'h7F09192946;
				8'd83: g = 40'h4649494931;
				8'd84: g = 40'h01017F0101;
				8'd85: g = 40'h3F4040403F;
				8'd86: g = 40'h1F2040201F;
				8'd87: g = 40'h3F4038403F;
				8'd88: g = 40'h6314081463;
				8'd89: g = 40'h0708700807;
				8'd90: g = 40'h6151494543;
				8'd48: g = 40'h3E5149453E;
				8'd49: g = 40'h00427F4000;
				8'd50: g = 40'h4261514946;
				8'd51: g = 40'h2141454B31;
				8'd52: g = 40'h1814127F10;
				8'd53: g = 40'h2745454539;
				8'd54: g = 40'h3C4A494930;
				8'd55: g = 40'h0171090503;
				8'd56: g = 40'h3649494936;
				8'd57: g = 40'h064949291E;
				8'd46: g = 40'h0060600000;
				8'd45: g = 40'h0808080808;
				8'd58: g = 40'h0036360000;
				8'd47: g = 40'h2010080402;
				default: g = 40'h0;
			endcase
			case (col)
				3'd0: font_col = g[38:32];
				3'd1: font_col = g[30:24];
				3'd2: font_col = g[22:16];
				3'd3: font_col = g[14:8];
				3'd4: font_col = g[6:0];
				default: font_col = 7'd0;
			endcase
		end
	endfunction
endpackage
`default_nettype wire

FILE: hdl/mfde_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module mfde_ram #(
	parameter int Width = 8,
	parameter int Depth = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: hdl/mono_framebuffer_draw_engine.sv
// Monochrome page framebuffer drawing engine: sequencer plus frame store.
// Depends on mfde_pkg and mfde_ram.
// One command at a time, one result word each. Each drawn point is read, then written back
// only where it lies on screen (and, for a glyph, where its font bit is set); every font
// cell of a glyph is read. A clear command and reset both sweep the whole store to zero.
// Next word is taken the cycle after the result leaves. Reset gives no result word.
`default_nettype none
module mono_framebuffer_draw_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic signed [10:0] x_a,
	input  wire logic signed [10:0] y_a,
	input  wire logic signed [10:0] x_b,
	input  wire logic signed [10:0] y_b,
	input  wire logic        pixel_on,
	input  wire logic [7:0]  char_code,
	input  wire logic [3:0]  scale,
	input  wire logic        whole_glyph_only,
	input  wire logic [9:0]  read_index,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [7:0]  read_data,
	output logic             is_read
);
	localparam int AW = mfde_pkg::AddrW;
	localparam logic [2:0] ST_IDLE = 3'd0, ST_CLR = 3'd1, ST_GEN = 3'd2, ST_WR = 3'd3,
		ST_RD = 3'd4, ST_DONE = 3'd5;

	logic [2:0] st_q;
	logic [AW:0] clr_q;
	logic [2:0] req_q;
	logic signed [12:0] xa_q, ya_q, xb_q, yb_q;
	logic on_q, rd_oob_q;
	logic [7:0] code_q;
	logic [3:0] sc_q;
	logic [1:0] seg_q;
	logic signed [12:0] i_q, end_q;
	logic [2:0] col_q, row_q;
	logic [3:0] dx_q, dy_q;
	logic pv_q;
	logic last_q;
	logic [AW-1:0] addr_q;
	logic [7:0] mask_q;
	logic boot_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0] wdata, rdata;

	mfde_ram #(.Width(8), .Depth(mfde_pkg::StoreBytes)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic accept;
	assign accept = in_valid && !in_stall;
	assign in_stall = (st_q != ST_IDLE) || out_valid;

	// current point generator
	logic signed [12:0] gx, gy;
	logic glyph_bit;
	logic [6:0] fcol;
	logic signed [12:0] cx, cy;
	always_comb begin
		fcol = mfde_pkg::font_col(code_q, col_q);
		glyph_bit = fcol[row_q];
		cx = 13'(col_q) * 13'(sc_q);
		cy = 13'(row_q) * 13'(sc_q);
		gx = xa_q; gy = ya_q;
		case (req_q)
			mfde_pkg::REQ_HLINE: begin gx = i_q; gy = ya_q; end
			mfde_pkg::REQ_VLINE: begin gx = xa_q; gy = i_q; end
			mfde_pkg::REQ_RECT: begin
				case (seg_q)
					2'd0: begin gx = i_q; gy = ya_q; end
					2'd1: begin gx = i_q; gy = ya_q + yb_q - 13'sd1; end
					2'd2: begin gx = xa_q; gy = i_q; end
					default: begin gx = xa_q + xb_q - 13'sd1; gy = i_q; end
				endcase
			end
			mfde_pkg::REQ_GLYPH: begin gx = xa_q + cx + 13'(dx_q); gy = ya_q + cy + 13'(dy_q); end
			default: ;
		endcase
	end

	logic gen_valid, gen_last;
	always_comb begin
		gen_valid = 1'b1;
		gen_last = 1'b1;
		case (req_q)
			mfde_pkg::REQ_HLINE, mfde_pkg::REQ_VLINE: gen_last = (i_q == end_q);
			mfde_pkg::REQ_RECT: gen_last = (i_q == end_q) && (seg_q == 2'd3);
			mfde_pkg::REQ_GLYPH: begin
				gen_valid = glyph_bit;
				gen_last = (col_q == 3'd4) && (row_q == 3'd6) &&
					(dx_q == sc_q - 4'd1) && (dy_q == sc_q - 4'd1);
			end
			default: ;
		endcase
	end

	logic onscr;
	logic [12:0] gidx;
	assign onscr = gen_valid && gx >= 0 && gy >= 0 &&
		gx < 13'(mfde_pkg::ScreenWidth) && gy < 13'(mfde_pkg::ScreenHeight);
	assign gidx = 13'(gy >>> 3) * 13'(mfde_pkg::ScreenWidth) + 13'(gx);

	always_comb begin
		raddr = AW'(gidx);
		if (st_q == ST_IDLE) raddr = read_index[AW-1:0];
		we = 1'b0;
		waddr = addr_q;
		wdata = (req_q == mfde_pkg::REQ_PIXEL && !on_q) ? (rdata & ~mask_q) : (rdata | mask_q);
		if (st_q == ST_CLR) begin
			we = 1'b1; waddr = clr_q[AW-1:0]; wdata = 8'h00;
		end else if (st_q == ST_WR && pv_q) begin
			we = 1'b1;
		end
	end

	logic signed [12:0] sxa, sya, sxb, syb;
	assign sxa = 13'(x_a); assign sya = 13'(y_a);
	assign sxb = 13'(x_b); assign syb = 13'(y_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			clr_q <= '0;
			out_valid <= 1'b0;
			read_data <= '0;
			is_read <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (st_q)
				ST_IDLE: if (accept) begin
					req_q <= req_type; on_q <= pixel_on; code_q <= char_code; sc_q <= scale;
					xa_q <= sxa; ya_q <= sya; xb_q <= sxb; yb_q <= syb;
					seg_q <= '0; col_q <= '0; row_q <= '0; dx_q <= '0; dy_q <= '0;
					rd_oob_q <= 11'(read_index) >= 11'(mfde_pkg::StoreBytes);
					case (req_type)
						mfde_pkg::REQ_CLEAR: begin clr_q <= '0; st_q <= ST_CLR; end
						mfde_pkg::REQ_PIXEL: st_q <= ST_GEN;
						mfde_pkg::REQ_HLINE: begin
							i_q <= (sxa > sxb) ? sxb : sxa; end_q <= (sxa > sxb) ? sxa : sxb;
							st_q <= ST_GEN;
						end
						mfde_pkg::REQ_VLINE: begin
							i_q <= (sya > syb) ? syb : sya; end_q <= (sya > syb) ? sya : syb;
							st_q <= ST_GEN;
						end
						mfde_pkg::REQ_RECT: begin
							i_q <= sxa; end_q <= sxa + sxb - 13'sd1;
							st_q <= (sxb < 1 || syb < 1) ? ST_DONE : ST_GEN;
						end
						mfde_pkg::REQ_GLYPH:
							st_q <= (scale == 4'd0 || sxa >= (whole_glyph_only ?
								13'(mfde_pkg::ScreenWidth - mfde_pkg::GlyphCols) :
								13'(mfde_pkg::ScreenWidth))) ? ST_DONE : ST_GEN;
						mfde_pkg::REQ_READ: st_q <= ST_RD;
						default: st_q <= ST_DONE;
					endcase
				end
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(mfde_pkg::StoreBytes - 1))
						st_q <= boot_q ? ST_IDLE : ST_DONE;
				end
				ST_GEN: begin
					pv_q <= onscr; addr_q <= AW'(gidx);
					mask_q <= 8'(1) << gy[2:0];
					last_q <= gen_last;
					st_q <= ST_WR;
					// advance
					case (req_q)
						mfde_pkg::REQ_RECT: if (i_q == end_q) begin
							seg_q <= seg_q + 2'd1;
							if (seg_q == 2'd0) begin i_q <= xa_q; end
							else begin i_q <= ya_q; end_q <= ya_q + yb_q - 13'sd1; end
						end else i_q <= i_q + 13'sd1;
						mfde_pkg::REQ_GLYPH: begin
							if (dy_q != sc_q - 4'd1) dy_q <= dy_q + 4'd1;
							else begin
								dy_q <= '0;
								if (dx_q != sc_q - 4'd1) dx_q <= dx_q + 4'd1;
								else begin
									dx_q <= '0;
									if (row_q != 3'd6) row_q <= row_q + 3'd1;
									else begin row_q <= '0; col_q <= col_q + 3'd1; end
								end
							end
						end
						default: i_q <= i_q + 13'sd1;
					endcase
				end
				ST_WR: st_q <= last_q ? ST_DONE : ST_GEN;
				ST_RD: begin
					read_data <= rd_oob_q ? 8'h00 : rdata;
					is_read <= 1'b1;
					out_valid <= 1'b1;
					st_q <= ST_IDLE;
				end
				ST_DONE: begin
					read_data <= '0;
					is_read <= 1'b0;
					out_valid <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// during the reset sweep no word may be reported
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) boot_q <= 1'b1;
		else if (st_q == ST_IDLE) boot_q <= 1'b0;
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> st_q == ST_IDLE && !out_valid) else $error("word taken while busy");
	a_read_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_read |-> read_data == 8'h00) else $error("non-read result has data");
	a_write_pair: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_WR |-> $past(st_q) == ST_GEN) else $error("write without read");
	a_boot: assert property (@(posedge clk) disable iff (!arst_n)
		boot_q |-> !out_valid) else $error("result during reset sweep");
endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for mono_framebuffer_draw_engine: random and directed drawing
// commands, a bit-level frame store predictor and a scoreboard of expected results.
// Depends on mfde_pkg and the engine RTL.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	localparam logic [2:0] REQ_NONE = 3'd7;

	typedef struct {
		logic [2:0] req;
		logic signed [10:0] xa, ya, xb, yb;
		logic on;
		logic [7:0] code;
		logic [3:0] sc;
		logic whole;
		logic [9:0] ridx;
	} draw_cmd_t;

	typedef struct {
		logic [7:0] data;
		logic rd;
	} read_word_t;

	class frame_scoreboard;
		logic [7:0] store [mfde_pkg::StoreBytes];
		read_word_t pending [$];
		int errors;
		int results;

		function void wipe();
			foreach (store[i]) store[i] = 8'h00;
		endfunction

		function void plot(int x, int y, bit on);
			int idx;
			if (x < 0 || y < 0 || x >= mfde_pkg::ScreenWidth || y >= mfde_pkg::ScreenHeight)
				return;
			idx = (y / 8) * mfde_pkg::ScreenWidth + x;
			store[idx][y % 8] = on;
		endfunction

		function void hspan(int a, int b, int y);
			int t;
			if (a > b) begin
				t = a; a = b; b = t;
			end
			for (int i = a; i <= b; i++) plot(i, y, 1);
		endfunction

		function void vspan(int x, int a, int b);
			int t;
			if (a > b) begin
				t = a; a = b; b = t;
			end
			for (int i = a; i <= b; i++) plot(x, i, 1);
		endfunction

		function logic [39:0] glyph_bits(logic [7:0] c);
			if (c >= "a" && c <= "z") c = c - 8'd32;
			case (c)
				"A": return 40'h7E1111117E; "B": return 40'h7F49494936;
				"C": return 40'h3E41414122; "D": return 40'h7F4141221C;
				"E": return 40'h7F49494941; "F": return 40'h7F09090901;
				"G": return 40'h3E4149497A; "H": return 40'h7F0808087F;
				"I": return 40'h00417F4100; "J": return 40'h2040413F01;
				"K": return 40'h7F08142241; "L": return 40'h7F40404040;
				"M": return 40'h7F020C027F; "N": return 40'h7F0408107F;
				"O": return 40'h3E4141413E; "P": return 40'h7F09090906;
				"Q": return 40'h3E4151215E; "R": return 40'h7F09192946;
				"S": return 40'h4649494931; "T": return 40'h01017F0101;
				"U": return 40'h3F4040403F; "V": return 40'h1F2040201F;
				"W": return 40'h3F4038403F; "X": return 40'h6314081463;
				"Y": return 40'h0708700807; "Z": return 40'h6151494543;
				"0": return 40'h3E5149453E; "1": return 40'h00427F4000;
				"2": return 40'h4261514946; "3": return 40'h2141454B31;
				"4": return 40'h1814127F10; "5": return 40'h2745454539;
				"6": return 40'h3C4A494930; "7": return 40'h0171090503;
				"8": return 40'h3649494936; "9": return 40'h064949291E;
				".": return 40'h0060600000; "-": return 40'h0808080808;
				":": return 40'h0036360000; "/": return 40'h2010080402;
				default: return 40'h0;
			endcase
		endfunction

		function void note_command(draw_cmd_t c);
			read_word_t w;
			logic [39:0] g;
			int lim;
			int sc;
			w.data = 8'h00;
			w.rd = 1'b0;
			sc = int'(c.sc);
			case (c.req)
				mfde_pkg::REQ_CLEAR: wipe();
				mfde_pkg::REQ_PIXEL: plot(c.xa, c.ya, c.on);
				mfde_pkg::REQ_HLINE: hspan(c.xa, c.xb, c.ya);
				mfde_pkg::REQ_VLINE: vspan(c.xa, c.ya, c.yb);
				mfde_pkg::REQ_RECT: if (c.xb >= 1 && c.yb >= 1) begin
					hspan(c.xa, c.xa + c.xb - 1, c.ya);
					hspan(c.xa, c.xa + c.xb - 1, c.ya + c.yb - 1);
					vspan(c.xa, c.ya, c.ya + c.yb - 1);
					vspan(c.xa + c.xb - 1, c.ya, c.ya + c.yb - 1);
				end
				mfde_pkg::REQ_GLYPH: begin
					lim = c.whole ? mfde_pkg::ScreenWidth - mfde_pkg::GlyphCols :
						mfde_pkg::ScreenWidth;
					g = glyph_bits(c.code);
					if (sc != 0 && int'(c.xa) < lim)
						for (int col = 0; col < mfde_pkg::GlyphCols; col++)
							for (int r = 0; r < mfde_pkg::GlyphRows; r++)
								if (g[(4 - col) * 8 + r])
									for (int dx = 0; dx < sc; dx++)
										for (int dy = 0; dy < sc; dy++)
											plot(int'(c.xa) + col * sc + dx,
												int'(c.ya) + r * sc + dy, 1);
				end
				mfde_pkg::REQ_READ: begin
					w.rd = 1'b1;
					if (c.ridx < mfde_pkg::StoreBytes) w.data = store[c.ridx];
				end
				default: ;
			endcase
			pending.push_back(w);
		endfunction

		function void check_word(logic [7:0] data, logic rd);
			read_word_t e;
			results++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word data=%h is_read=%b", $time, data, rd);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (data !== e.data) begin
				$display("%0t: read_data expected %h actual %h", $time, e.data, data);
				errors++;
			end
			if (rd !== e.rd) begin
				$display("%0t: is_read expected %b actual %b", $time, e.rd, rd);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] req_type = '0;
	logic signed [10:0] x_a = '0, y_a = '0, x_b = '0, y_b = '0;
	logic pixel_on = 1'b0;
	logic [7:0] char_code = '0;
	logic [3:0] scale = '0;
	logic whole_glyph_only = 1'b0;
	logic [9:0] read_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] read_data;
	logic is_read;

	frame_scoreboard sb = new();
	int send_idle_pct = 0;
	int stall_pct = 0;
	int idle_count = 0;
	int sent = 0;

	always #6 clk = ~clk;

	mono_framebuffer_draw_engine u_dut (.*);

	always @(posedge clk) begin
		if (out_valid && !out_stall && arst_n) sb.check_word(read_data, is_read);
		out_stall <= ($urandom_range(99) < stall_pct);
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count <= 0;
		else idle_count <= idle_count + 1;
		if (idle_count > 100000) begin
			$display("[mono_framebuffer_draw_engine] ERROR");
			$finish;
		end
	end

	task automatic send_word(draw_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= c.req; x_a <= c.xa; y_a <= c.ya; x_b <= c.xb; y_b <= c.yb;
		pixel_on <= c.on; char_code <= c.code; scale <= c.sc;
		whole_glyph_only <= c.whole; read_index <= c.ridx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_command(c);
		sent++;
	endtask

	function automatic draw_cmd_t make_cmd(logic [2:0] req, int xa, int ya, int xb, int yb);
		draw_cmd_t c;
		c.req = req; c.xa = 11'(xa); c.ya = 11'(ya); c.xb = 11'(xb); c.yb = 11'(yb);
		c.on = 1'($urandom_range(1)); c.code = 8'($urandom); c.sc = 4'($urandom_range(1, 2));
		c.whole = 1'($urandom_range(1));
		c.ridx = 10'($urandom_range(mfde_pkg::StoreBytes - 1));
		return c;
	endfunction

	function automatic int near_coord(int span);
		if ($urandom_range(9) == 0) return int'($signed(11'($urandom)));
		return $urandom_range(span + 8) - 8;
	endfunction

	function automatic draw_cmd_t random_cmd();
		draw_cmd_t c;
		int r = $urandom_range(99);
		logic [2:0] req;
		if (r < 30) req = mfde_pkg::REQ_READ;
		else if (r < 45) req = mfde_pkg::REQ_PIXEL;
		else if (r < 55) req = mfde_pkg::REQ_HLINE;
		else if (r < 65) req = mfde_pkg::REQ_VLINE;
		else if (r < 73) req = mfde_pkg::REQ_RECT;
		else if (r < 95) req = mfde_pkg::REQ_GLYPH;
		else if (r < 97) req = mfde_pkg::REQ_CLEAR;
		else req = REQ_NONE;
		c = make_cmd(req, near_coord(mfde_pkg::ScreenWidth), near_coord(mfde_pkg::ScreenHeight),
			0, 0);
		if (req == mfde_pkg::REQ_HLINE) c.xb = 11'(near_coord(mfde_pkg::ScreenWidth));
		else c.xb = 11'($urandom_range(20) - 2);
		if (req == mfde_pkg::REQ_VLINE) c.yb = 11'(near_coord(mfde_pkg::ScreenHeight));
		else c.yb = 11'($urandom_range(20) - 2);
		if ($urandom_range(19) == 0) begin
			c.xb = $signed(11'($urandom));
			c.yb = $signed(11'($urandom));
		end
		if (req == mfde_pkg::REQ_GLYPH) begin
			c.code = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(32, 122));
			c.sc = ($urandom_range(15) == 0) ? 4'($urandom) : 4'($urandom_range(3));
			if (c.sc > 4 && $urandom_range(1)) c.xa = 11'(mfde_pkg::ScreenWidth - 3);
		end
		if ($urandom_range(9) == 0) c.ridx = 10'($urandom);
		return c;
	endfunction

	initial begin
		draw_cmd_t c;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, every command, reversed lines, folding, blank codes
		send_word(make_cmd(mfde_pkg::REQ_PIXEL, 0, 0, 0, 0));
		c = make_cmd(mfde_pkg::REQ_PIXEL, mfde_pkg::ScreenWidth - 1,
			mfde_pkg::ScreenHeight - 1, 0, 0);
		c.on = 1'b1;
		send_word(c);
		send_word(make_cmd(mfde_pkg::REQ_PIXEL, -1024, 1023, -1024, 1023));
		send_word(make_cmd(mfde_pkg::REQ_HLINE, 130, -5, 0, 0));
		send_word(make_cmd(mfde_pkg::REQ_HLINE, 1023, 9, -1024, 0));
		send_word(make_cmd(mfde_pkg::REQ_VLINE, 7, 70, 0, -3));
		send_word(make_cmd(mfde_pkg::REQ_RECT, 20, 20, 0, 5));
		send_word(make_cmd(mfde_pkg::REQ_RECT, 20, 20, 1, 1));
		send_word(make_cmd(mfde_pkg::REQ_RECT, 30, 10, 15, 9));
		c = make_cmd(mfde_pkg::REQ_GLYPH, 40, 30, 0, 0); c.code = "q"; c.sc = 4'd1;
		send_word(c);
		c = make_cmd(mfde_pkg::REQ_GLYPH, 50, 30, 0, 0); c.code = 8'd200; c.sc = 4'd2;
		send_word(c);
		c = make_cmd(mfde_pkg::REQ_GLYPH, mfde_pkg::ScreenWidth - 5, 0, 0, 0);
		c.code = "A"; c.sc = 4'd1;
		c.whole = 1'b1; send_word(c);
		c.whole = 1'b0; send_word(c);
		c = make_cmd(mfde_pkg::REQ_GLYPH, 60, 0, 0, 0); c.code = "8"; c.sc = 4'd0;
		send_word(c);
		c = make_cmd(mfde_pkg::REQ_GLYPH, -3, 40, 0, 0); c.code = "M"; c.sc = 4'd15;
		send_word(c);
		for (int i = 0; i < 6; i++) begin
			c = make_cmd(mfde_pkg::REQ_READ, 0, 0, 0, 0);
			c.ridx = (i == 5) ? 10'h3FF : 10'($urandom_range(mfde_pkg::StoreBytes - 1));
			send_word(c);
		end
		send_word(make_cmd(REQ_NONE, 0, 0, 0, 0));
		send_word(make_cmd(mfde_pkg::REQ_CLEAR, 0, 0, 0, 0));
		c = make_cmd(mfde_pkg::REQ_READ, 0, 0, 0, 0); c.ridx = 10'd0; send_word(c);
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 8 : 51) : 0;
			stall_pct = (ph == 2) ? 51 : ((ph == 3) ? 8 : 0);
			for (int i = 0; i < 150; i++) send_word(random_cmd());
			in_valid <= 1'b0;
			@(posedge clk);
		end
		stall_pct = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Sent %0d commands (all kinds, four handshake phases), checked %0d words.",
			sent, sb.results);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[mono_framebuffer_draw_engine] OK");
		else
			$display("[mono_framebuffer_draw_engine] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
